// File: rtl/assert_macros.svh
// assertion helpers, clocked on clk and held off while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// condition implies consequence in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/bpzr_pkg.sv
package bpzr_pkg;

	localparam int MAX_TILES       = 7;
	localparam int MAX_PREFIX_BITS = 11;

	localparam int TILE_W     = 3;
	localparam int VALUE_W    = 2;
	localparam int REPEAT_W   = 12;
	localparam int START_W    = 11;
	localparam int REPEAT_MAX = (1 << REPEAT_W) - 1;

	// run fields: prefix and value both hold at most MAX_PREFIX_BITS bits
	localparam int ACC_W   = MAX_PREFIX_BITS;
	localparam int LEN_W   = $clog2(MAX_PREFIX_BITS + 1);
	localparam int N_W     = ACC_W + 2;
	localparam int PLANE_W = $clog2(32 * MAX_TILES * MAX_TILES + 1);
	localparam int SUM_W   = ((N_W > PLANE_W) ? N_W : PLANE_W) + 1;

	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 3;

	// register indexes
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic [VALUE_W-1:0]  pair_value;
		logic [REPEAT_W-1:0] repeat_count;
		logic [START_W-1:0]  start_pair;
		logic                plane_done;
		logic                prefix_overflow;
	} token_t;

	// handshake between the input register and the decoder
	typedef struct packed {
		logic valid;
		logic data;
	} bit_stage_t;

	function automatic logic [PLANE_W-1:0] plane_pairs(input logic [TILE_W-1:0] w,
			input logic [TILE_W-1:0] h);
		logic [PLANE_W-1:0] wc;
		logic [PLANE_W-1:0] hc;
		wc = (PLANE_W'(w) > PLANE_W'(MAX_TILES)) ? PLANE_W'(MAX_TILES) : PLANE_W'(w);
		hc = (PLANE_W'(h) > PLANE_W'(MAX_TILES)) ? PLANE_W'(MAX_TILES) : PLANE_W'(h);
		return PLANE_W'((wc * hc) << 5);
	endfunction

endpackage

// File: rtl/bpzr_cfg.sv
module bpzr_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [bpzr_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [bpzr_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [bpzr_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                              pready,
	output logic [bpzr_pkg::PLANE_W-1:0]      plane_size
);
	import bpzr_pkg::*;

	logic [TILE_W-1:0] width_q;
	logic [TILE_W-1:0] height_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= TILE_W'(7);
			height_q <= TILE_W'(7);
		end else if (wr_en) begin
			if (paddr[2] == REG_WIDTH) begin
				width_q <= pwdata[TILE_W-1:0];
			end else begin
				height_q <= pwdata[TILE_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == REG_WIDTH) begin
			prdata = CFG_DATA_W'(width_q);
		end else begin
			prdata = CFG_DATA_W'(height_q);
		end
	end

	assign plane_size = plane_pairs(width_q, height_q);

endmodule

// File: rtl/bpzr_in_reg.sv
module bpzr_in_reg (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   bit_valid,
	output logic                   bit_ready,
	input  logic                   stream_bit,
	input  logic                   take,
	output bpzr_pkg::bit_stage_t   stage
);
	import bpzr_pkg::*;

	logic valid_s1;
	logic data_s1;

	assign bit_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bit_ready) begin
			valid_s1 <= bit_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bit_valid && bit_ready) begin
			data_s1 <= stream_bit;
		end
	end

	assign stage.valid = valid_s1;
	assign stage.data  = data_s1;

endmodule

// File: rtl/bpzr_decode.sv
`include "assert_macros.svh"

module bpzr_decode (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bpzr_pkg::bit_stage_t          stage,
	output logic                          take,
	input  logic [bpzr_pkg::PLANE_W-1:0]  plane_size,
	output logic                          token_valid,
	input  logic                          token_ready,
	output bpzr_pkg::token_t              token
);
	import bpzr_pkg::*;

	localparam logic [2:0] PH_TYPE    = 3'd0;
	localparam logic [2:0] PH_PREFIX  = 3'd1;
	localparam logic [2:0] PH_VALUE   = 3'd2;
	localparam logic [2:0] PH_PAIR_HI = 3'd3;
	localparam logic [2:0] PH_PAIR_LO = 3'd4;

	logic [2:0]         phase_q, phase_d;
	logic [ACC_W-1:0]   prefix_acc_q, prefix_acc_d;
	logic [LEN_W-1:0]   prefix_len_q, prefix_len_d;
	logic [ACC_W-1:0]   value_acc_q, value_acc_d;
	logic [LEN_W-1:0]   value_left_q, value_left_d;
	logic               high_bit_q, high_bit_d;
	logic [PLANE_W-1:0] pair_cnt_q, pair_cnt_d;

	logic               out_valid_q;
	token_t             token_q;

	logic               b;
	logic               emit;
	logic               ovf;
	logic [VALUE_W-1:0] emit_val;
	logic [N_W-1:0]     emit_n;
	logic [2:0]         emit_next;
	logic [SUM_W-1:0]   sum;
	logic               done;
	token_t             tok;

	assign take = stage.valid && (!out_valid_q || token_ready);
	assign b    = stage.data;

	always_comb begin
		phase_d      = phase_q;
		prefix_acc_d = prefix_acc_q;
		prefix_len_d = prefix_len_q;
		value_acc_d  = value_acc_q;
		value_left_d = value_left_q;
		high_bit_d   = high_bit_q;
		pair_cnt_d   = pair_cnt_q;
		emit         = 1'b0;
		ovf          = 1'b0;
		emit_val     = '0;
		emit_n       = '0;
		emit_next    = PH_PAIR_HI;
		case (phase_q)
			PH_TYPE: begin
				pair_cnt_d   = '0;
				prefix_acc_d = '0;
				prefix_len_d = '0;
				phase_d      = b ? PH_PAIR_HI : PH_PREFIX;
			end
			PH_PREFIX: begin
				if (b && (prefix_len_q >= LEN_W'(MAX_PREFIX_BITS - 1))) begin
					// prefix too long: drop the run and wait for a new plane
					ovf          = 1'b1;
					pair_cnt_d   = '0;
					prefix_acc_d = '0;
					prefix_len_d = '0;
					phase_d      = PH_TYPE;
				end else begin
					prefix_acc_d = {prefix_acc_q[ACC_W-2:0], b};
					prefix_len_d = prefix_len_q + LEN_W'(1);
					if (!b) begin
						value_acc_d  = '0;
						value_left_d = prefix_len_q + LEN_W'(1);
						phase_d      = PH_VALUE;
					end
				end
			end
			PH_VALUE: begin
				value_acc_d = {value_acc_q[ACC_W-2:0], b};
				if (value_left_q != '0) begin
					value_left_d = value_left_q - LEN_W'(1);
				end
				if (value_left_d == '0) begin
					emit         = 1'b1;
					emit_n       = N_W'(prefix_acc_q) + N_W'(value_acc_d) + N_W'(1);
					prefix_acc_d = '0;
					prefix_len_d = '0;
					value_acc_d  = '0;
				end
			end
			PH_PAIR_HI: begin
				high_bit_d = b;
				phase_d    = PH_PAIR_LO;
			end
			PH_PAIR_LO: begin
				high_bit_d = 1'b0;
				if (!high_bit_q && !b) begin
					// 00 pair closes the data packet, a run follows
					prefix_acc_d = '0;
					prefix_len_d = '0;
					phase_d      = PH_PREFIX;
				end else begin
					emit     = 1'b1;
					emit_val = {high_bit_q, b};
					emit_n   = N_W'(1);
				end
			end
			default: begin
				phase_d = PH_TYPE;
			end
		endcase

		sum  = SUM_W'(pair_cnt_q) + SUM_W'(emit_n);
		done = sum >= SUM_W'(plane_size);

		tok.pair_value      = emit_val;
		tok.start_pair      = START_W'(pair_cnt_q);
		tok.plane_done      = 1'b0;
		tok.prefix_overflow = ovf;
		tok.repeat_count    = '0;
		if (emit) begin
			if (SUM_W'(emit_n) > SUM_W'(REPEAT_MAX)) begin
				tok.repeat_count = '1;
			end else begin
				tok.repeat_count = REPEAT_W'(emit_n);
			end
			tok.plane_done = done;
			if (done) begin
				pair_cnt_d = '0;
				phase_d    = PH_TYPE;
			end else begin
				pair_cnt_d = PLANE_W'(sum);
				phase_d    = emit_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_TYPE;
			prefix_acc_q <= '0;
			prefix_len_q <= '0;
			value_acc_q  <= '0;
			value_left_q <= '0;
			high_bit_q   <= 1'b0;
			pair_cnt_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (take) begin
				phase_q      <= phase_d;
				prefix_acc_q <= prefix_acc_d;
				prefix_len_q <= prefix_len_d;
				value_acc_q  <= value_acc_d;
				value_left_q <= value_left_d;
				high_bit_q   <= high_bit_d;
				pair_cnt_q   <= pair_cnt_d;
			end
			if (take && (emit || ovf)) begin
				out_valid_q <= 1'b1;
			end else if (token_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && (emit || ovf)) begin
			token_q <= tok;
		end
	end

	assign token_valid = out_valid_q;
	assign token       = token_q;

	`ASSERT_IMPL(a_value_left_live, phase_q == PH_VALUE, value_left_q != '0)
	`ASSERT_IMPL(a_prefix_len_bound, phase_q == PH_PREFIX,
		prefix_len_q <= LEN_W'(MAX_PREFIX_BITS - 1))
	`ASSERT_NEXT(a_done_to_type, take && emit && done, phase_q == PH_TYPE && pair_cnt_q == '0)
	`ASSERT_IMPL(a_ovf_token, out_valid_q && token_q.prefix_overflow,
		token_q.repeat_count == '0 && !token_q.plane_done && token_q.pair_value == '0)

endmodule

// File: rtl/bit_pair_zero_run_decoder.sv
// bit-pair / zero-run decoder for one bitplane
// input channel: one compressed bit per word on stream_bit (bit_valid/bit_ready)
// output channel: one token per word (token_valid/token_ready) carrying pair_value,
//   repeat_count, start_pair, plane_done and prefix_overflow
// a bit is held in an input register, then decoded against the packet state into
//   a result register, from which the token that it completes is offered
// throughput is one bit per cycle when no token stalls, one decode step per bit
// many bits give no token (type bit, prefix and value bits, high pair bits)
// when token_ready is low the result register holds; one more bit may be
//   taken into the input register, then bit_ready drops until the token leaves
// width_tiles (byte address 0) and height_tiles (byte address 4) are written
//   over the apb port, 3 bits each; plane size is 32 * width * height pairs
// reset: both tile registers are 7, the decoder waits for a plane's type bit,
//   the pair counter is zero and no token is pending
module bit_pair_zero_run_decoder (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [bpzr_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [bpzr_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [bpzr_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                              pready,
	input  logic                              bit_valid,
	output logic                              bit_ready,
	input  logic                              stream_bit,
	output logic                              token_valid,
	input  logic                              token_ready,
	output logic [bpzr_pkg::VALUE_W-1:0]      pair_value,
	output logic [bpzr_pkg::REPEAT_W-1:0]     repeat_count,
	output logic [bpzr_pkg::START_W-1:0]      start_pair,
	output logic                              plane_done,
	output logic                              prefix_overflow
);
	import bpzr_pkg::*;

	logic [PLANE_W-1:0] plane_size;
	bit_stage_t         stage;
	logic               take;
	token_t             token;

	bpzr_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.plane_size (plane_size)
	);

	bpzr_in_reg u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.bit_valid  (bit_valid),
		.bit_ready  (bit_ready),
		.stream_bit (stream_bit),
		.take       (take),
		.stage      (stage)
	);

	bpzr_decode u_dec (
		.clk         (clk),
		.arst_n      (arst_n),
		.stage       (stage),
		.take        (take),
		.plane_size  (plane_size),
		.token_valid (token_valid),
		.token_ready (token_ready),
		.token       (token)
	);

	assign pair_value      = token.pair_value;
	assign repeat_count    = token.repeat_count;
	assign start_pair      = token.start_pair;
	assign plane_done      = token.plane_done;
	assign prefix_overflow = token.prefix_overflow;

endmodule
